FILE: sv/fgr_pkg.sv
package fgr_pkg;

    // Input item kinds.
    typedef enum logic [1:0] {
        KIND_MAP  = 2'd0,
        KIND_FONT = 2'd1,
        KIND_DRAW = 2'd2,
        KIND_NONE = 2'd3
    } fgr_kind_t;

    // Configuration register indexes (byte address bits [3:2]).
    typedef enum logic [1:0] {
        REG_FG_COLOR    = 2'd0,
        REG_BG_COLOR    = 2'd1,
        REG_SCREEN_BASE = 2'd2,
        REG_UNUSED      = 2'd3
    } fgr_reg_t;

    // Draw sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOD,
        ST_FONT,
        ST_EMIT,
        ST_EMPTY
    } fgr_state_t;

    localparam logic [7:0] FG_RESET      = 8'hff;
    localparam logic [7:0] BG_RESET      = 8'h00;
    localparam logic [3:0] MAX_WIDTH     = 4'd8;
    localparam logic [3:0] DEFAULT_WIDTH = 4'd6;
    localparam logic [7:0] CODE_TILDE    = 8'h7e;
    localparam logic [7:0] CODE_CTRL0    = 8'hf0;
    localparam logic [7:0] CODE_CTRL1    = 8'hf1;
    localparam logic [7:0] CODE_CTRL2    = 8'hf2;
    localparam logic [7:0] CODE_CTRL3    = 8'hf3;

    // Advance width used when a character has no map entry.
    function automatic logic [3:0] fgr_default_width(input logic [7:0] code);
        logic [3:0] w;
        if (code == CODE_TILDE || code == CODE_CTRL0 || code == CODE_CTRL1 ||
            code == CODE_CTRL2 || code == CODE_CTRL3)
        begin
            w = 4'd0;
        end
        else
        begin
            w = DEFAULT_WIDTH;
        end
        return w;
    endfunction

endpackage

FILE: sv/fgr_if.sv
// Command channel: map loads, font loads and draw requests.
interface fgr_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [6:0] map_slot;
    logic [7:0] glyph_number;
    logic [3:0] glyph_columns;
    logic [10:0] font_address;
    logic [7:0] font_byte;
    logic [8:0] pos_x;
    logic [7:0] pos_y;

    modport source (
        output valid, kind, char_code, map_slot, glyph_number, glyph_columns,
               font_address, font_byte, pos_x, pos_y,
        input  ready
    );
    modport sink (
        input  valid, kind, char_code, map_slot, glyph_number, glyph_columns,
               font_address, font_byte, pos_x, pos_y,
        output ready
    );
endinterface

// Pixel channel: one item per drawn pixel.
interface fgr_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_offset;
    logic [7:0]  pixel_color;
    logic        pixel_valid;
    logic [3:0]  advance_width;
    logic        last;

    modport source (
        output valid, pixel_offset, pixel_color, pixel_valid, advance_width, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_offset, pixel_color, pixel_valid, advance_width, last,
        output ready
    );
endinterface

FILE: sv/font_glyph_renderer_core.sv
// 8x8 bitmap font character generator.
// The cmd channel takes three kinds of item: a map load writes one character
// map slot (code, glyph number, width saturated at 8), a font load writes one
// glyph row byte, and a draw looks a character up and renders it. Loads
// produce nothing. A draw produces DRAW_ROWS times width items
// on the pix channel, row-major, each with its wrapped framebuffer offset and
// palette index; the final one has last set. A width-0 character gives one
// item with pixel_valid low. Colors and screen base are set over the APB port.
// Steps of a draw: the map is scanned one slot a cycle through a one-stage
// read pipeline until a hit or the last slot; the glyph number is then
// reduced modulo GLYPH_COUNT by repeated subtraction; each row reads its
// font byte in ST_FONT, then emits its columns in order, holding while the
// pix receiver stalls.
// cmd.ready is high only while no draw is in progress.
// A stalled pix receiver holds the sequencer in place; nothing is dropped.
// Reset clears the map valid bits at once and sets the colors to white on
// black and the base to 0; font and map contents are undefined until loaded.
module font_glyph_renderer_core
    import fgr_pkg::*;
#(
    parameter int MAP_ENTRIES = 74,
    parameter int GLYPH_COUNT = 256,
    parameter int DRAW_ROWS   = 7,
    parameter int LINE_PITCH  = 320
)
(
    input  logic        clk,
    input  logic        rst_n,
    fgr_cmd_if.sink     cmd,
    fgr_pix_if.source   pix,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MI_W       = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int FONT_BYTES = GLYPH_COUNT * 8;
    localparam int FA_W       = $clog2(FONT_BYTES);
    localparam logic [15:0] PITCH16   = 16'(LINE_PITCH);
    localparam logic [2:0]  LAST_ROW  = 3'(DRAW_ROWS - 1);
    localparam logic [MI_W-1:0] LAST_SLOT = MI_W'(MAP_ENTRIES - 1);

    // Configuration registers.
    logic [7:0]  fg_reg;
    logic [7:0]  bg_reg;
    logic [15:0] base_cfg_reg;
    logic        cfg_wr;
    fgr_reg_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = fgr_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg       <= FG_RESET;
            bg_reg       <= BG_RESET;
            base_cfg_reg <= 16'd0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FG_COLOR:    fg_reg       <= pwdata[7:0];
                REG_BG_COLOR:    bg_reg       <= pwdata[7:0];
                REG_SCREEN_BASE: base_cfg_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (cfg_idx)
            REG_FG_COLOR:    prdata = {24'd0, fg_reg};
            REG_BG_COLOR:    prdata = {24'd0, bg_reg};
            REG_SCREEN_BASE: prdata = {16'd0, base_cfg_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Sequencer and datapath registers.
    fgr_state_t     state_reg, state_next;
    logic [7:0]     code_reg, code_next;
    logic [15:0]    start_reg, start_next;
    logic [MI_W-1:0] issue_idx_reg, issue_idx_next;
    logic           issue_on_reg, issue_on_next;
    logic           stage_vld_reg, stage_vld_next;
    logic           stage_last_reg, stage_last_next;
    logic           vbit_q_reg;
    logic [7:0]     glyph_reg, glyph_next;
    logic [3:0]     width_reg, width_next;
    logic [2:0]     row_reg, row_next;
    logic [2:0]     col_reg, col_next;
    logic [15:0]    row_off_reg, row_off_next;
    logic [15:0]    pix_off_reg, pix_off_next;

    // Output register.
    logic           out_valid_reg, out_valid_next;
    logic [15:0]    out_off_reg, out_off_next;
    logic [7:0]     out_color_reg, out_color_next;
    logic           out_pv_reg, out_pv_next;
    logic [3:0]     out_aw_reg, out_aw_next;
    logic           out_last_reg, out_last_next;

    // Memories and their registered read data.
    logic           map_valid_reg [MAP_ENTRIES];
    logic [7:0]     map_key_mem   [MAP_ENTRIES];
    logic [7:0]     map_glyph_mem [MAP_ENTRIES];
    logic [3:0]     map_width_mem [MAP_ENTRIES];
    logic [7:0]     font_mem      [FONT_BYTES];
    logic [7:0]     key_q_reg;
    logic [7:0]     glyph_q_reg;
    logic [3:0]     width_q_reg;
    logic [7:0]     font_q_reg;

    logic           cmd_acc;
    fgr_kind_t      cmd_kind;
    logic [8:0]     slot_ext;
    logic           map_we;
    logic           font_we;
    logic [MI_W-1:0] map_waddr;
    logic [3:0]     sat_width;
    logic [FA_W-1:0] font_raddr;
    logic           out_free;
    logic           scan_hit;
    logic           scan_miss;
    logic [3:0]     dflt_width;
    logic [3:0]     found_width;
    logic           col_last;
    logic           row_last;
    logic           emit_pix;
    logic           emit_empty;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cmd_kind  = fgr_kind_t'(cmd.kind);
    assign slot_ext  = {2'd0, cmd.map_slot};
    assign map_we    = cmd_acc && cmd_kind == KIND_MAP && slot_ext < 9'(MAP_ENTRIES);
    assign font_we   = cmd_acc && cmd_kind == KIND_FONT &&
                       {1'b0, cmd.font_address} < 12'(FONT_BYTES);
    assign map_waddr = slot_ext[MI_W-1:0];
    assign sat_width = (cmd.glyph_columns > MAX_WIDTH) ? MAX_WIDTH : cmd.glyph_columns;
    // Glyph is already below GLYPH_COUNT here, so the address stays in range.
    assign font_raddr = FA_W'({glyph_reg, row_reg});

    // Map valid bits, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_ENTRIES; i++)
            begin
                map_valid_reg[i] <= 1'b0;
            end
        end
        else if (map_we)
        begin
            map_valid_reg[map_waddr] <= 1'b1;
        end
    end

    // Map memory: one write port, one registered read port at the scan index.
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_key_mem[map_waddr]   <= cmd.char_code;
            map_glyph_mem[map_waddr] <= cmd.glyph_number;
            map_width_mem[map_waddr] <= sat_width;
        end
        key_q_reg   <= map_key_mem[issue_idx_reg];
        glyph_q_reg <= map_glyph_mem[issue_idx_reg];
        width_q_reg <= map_width_mem[issue_idx_reg];
        vbit_q_reg  <= map_valid_reg[issue_idx_reg];
    end

    // Font memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[cmd.font_address[FA_W-1:0]] <= cmd.font_byte;
        end
        font_q_reg <= font_mem[font_raddr];
    end

    // Lookup compare on the map entry read in the previous cycle.
    assign scan_hit    = stage_vld_reg && vbit_q_reg && key_q_reg == code_reg;
    assign scan_miss   = stage_vld_reg && stage_last_reg && !scan_hit;
    assign dflt_width  = fgr_default_width(code_reg);
    assign found_width = scan_hit ? width_q_reg : dflt_width;

    assign out_free   = !out_valid_reg || pix.ready;
    assign col_last   = {1'b0, col_reg} == (width_reg - 4'd1);
    assign row_last   = row_reg == LAST_ROW;
    assign emit_pix   = (state_reg == ST_EMIT) && out_free;
    assign emit_empty = (state_reg == ST_EMPTY) && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc && cmd_kind == KIND_DRAW)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || scan_miss)
                begin
                    state_next = (found_width == 4'd0) ? ST_EMPTY : ST_MOD;
                end
            end
            ST_MOD:
            begin
                if ({1'b0, glyph_reg} < 9'(GLYPH_COUNT))
                begin
                    state_next = ST_FONT;
                end
            end
            ST_FONT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free && col_last)
                begin
                    state_next = row_last ? ST_IDLE : ST_FONT;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register next values.
    always_comb
    begin
        code_next       = code_reg;
        start_next      = start_reg;
        issue_idx_next  = issue_idx_reg;
        issue_on_next   = issue_on_reg;
        stage_vld_next  = 1'b0;
        stage_last_next = 1'b0;
        glyph_next      = glyph_reg;
        width_next      = width_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        row_off_next    = row_off_reg;
        pix_off_next    = pix_off_reg;

        out_valid_next  = out_valid_reg && !pix.ready;
        out_off_next    = out_off_reg;
        out_color_next  = out_color_reg;
        out_pv_next     = out_pv_reg;
        out_aw_next     = out_aw_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Latch the draw and its top left offset; start the scan.
                code_next      = cmd.char_code;
                start_next     = base_cfg_reg + PITCH16 * {8'd0, cmd.pos_y} +
                                 {7'd0, cmd.pos_x};
                issue_idx_next = '0;
                issue_on_next  = 1'b1;
            end
            ST_SCAN:
            begin
                stage_vld_next  = issue_on_reg;
                stage_last_next = issue_on_reg && issue_idx_reg == LAST_SLOT;
                if (issue_on_reg)
                begin
                    if (issue_idx_reg == LAST_SLOT)
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + MI_W'(1);
                    end
                end
                glyph_next   = scan_hit ? glyph_q_reg : 8'd0;
                width_next   = found_width;
                row_next     = 3'd0;
                col_next     = 3'd0;
                row_off_next = start_reg;
                pix_off_next = start_reg;
            end
            ST_MOD:
            begin
                // Wrap the glyph number into the font store, one subtract a cycle.
                if ({1'b0, glyph_reg} >= 9'(GLYPH_COUNT))
                begin
                    glyph_next = 8'({1'b0, glyph_reg} - 9'(GLYPH_COUNT));
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = pix_off_reg;
                    out_color_next = font_q_reg[3'd7 - col_reg] ? fg_reg : bg_reg;
                    out_pv_next    = 1'b1;
                    out_aw_next    = width_reg;
                    out_last_next  = col_last && row_last;
                    if (col_last)
                    begin
                        col_next     = 3'd0;
                        row_next     = row_reg + 3'd1;
                        row_off_next = row_off_reg + PITCH16;
                        pix_off_next = row_off_reg + PITCH16;
                    end
                    else
                    begin
                        col_next     = col_reg + 3'd1;
                        pix_off_next = pix_off_reg + 16'd1;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = 16'd0;
                    out_color_next = 8'd0;
                    out_pv_next    = 1'b0;
                    out_aw_next    = 4'd0;
                    out_last_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_on_reg   <= 1'b0;
            stage_vld_reg  <= 1'b0;
            stage_last_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_on_reg   <= issue_on_next;
            stage_vld_reg  <= stage_vld_next;
            stage_last_reg <= stage_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        start_reg     <= start_next;
        issue_idx_reg <= issue_idx_next;
        glyph_reg     <= glyph_next;
        width_reg     <= width_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        row_off_reg   <= row_off_next;
        pix_off_reg   <= pix_off_next;
        out_off_reg   <= out_off_next;
        out_color_reg <= out_color_next;
        out_pv_reg    <= out_pv_next;
        out_aw_reg    <= out_aw_next;
        out_last_reg  <= out_last_next;
    end

    assign pix.valid         = out_valid_reg;
    assign pix.pixel_offset  = out_off_reg;
    assign pix.pixel_color   = out_color_reg;
    assign pix.pixel_valid   = out_pv_reg;
    assign pix.advance_width = out_aw_reg;
    assign pix.last          = out_last_reg;

    // An empty result always closes its draw and reports width zero.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_pv_reg) |-> (out_last_reg && out_aw_reg == 4'd0))
        else $error("empty result without last or with nonzero width");

    // A pixel result carries a width between one and eight.
    a_pixel_width: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pv_reg) |-> (out_aw_reg != 4'd0 && out_aw_reg <= MAX_WIDTH))
        else $error("pixel result with an impossible advance width");

    // The scan always ends once the last slot has been compared.
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && stage_vld_reg && stage_last_reg) |=>
        (state_reg != ST_SCAN))
        else $error("lookup kept scanning past the last map slot");

    // Issuing the final pixel of a draw returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_pix && col_last && row_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not go idle after the final pixel");

    // Pixel colors come from the two palette registers.
    a_color_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pv_reg) |->
        (out_color_reg == fg_reg || out_color_reg == bg_reg))
        else $error("pixel color is neither foreground nor background");

    // An empty draw result is only produced from the empty state.
    a_empty_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && !out_pv_reg |-> $past(emit_empty))
        else $error("empty result produced outside the empty-draw path");

endmodule
